### hdl/two_axis_servo_interpolator_defines.svh
// Assertion helpers shared by the interpolator modules.
// Each expects signals named clk and rst_n in the using scope.
`ifndef TWO_AXIS_SERVO_INTERPOLATOR_DEFINES_SVH
`define TWO_AXIS_SERVO_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define TASI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TASI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tasi_pkg.sv
`timescale 1ns / 1ps

package tasi_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W  = 8;
    localparam int STEP_W = 16;
    localparam int DUR_W  = 25;
    localparam int QUO_W  = 32;
    localparam int CNT_W  = $clog2(QUO_W);

    localparam logic [DUR_W-1:0] TICK_MS = DUR_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEG_MUL,
        ST_SEG_DIV,
        ST_DECIDE,
        ST_AX_MUL,
        ST_AX_DIV,
        ST_DONE
    } state_t;

endpackage

### hdl/tasi_div.sv
`timescale 1ns / 1ps
`include "two_axis_servo_interpolator_defines.svh"

// Restoring divider, one quotient bit per cycle.
module tasi_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tasi_pkg::QUO_W-1:0]   dividend,
    input  logic [tasi_pkg::DUR_W-1:0]   divisor,
    output logic                         done,
    output logic [tasi_pkg::QUO_W-1:0]   quotient,
    output logic [tasi_pkg::DUR_W-1:0]   remainder
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [tasi_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [tasi_pkg::QUO_W-1:0]   quo_reg, quo_next;
    logic [tasi_pkg::DUR_W-1:0]   rem_reg, rem_next;
    logic [tasi_pkg::DUR_W-1:0]   dvs_reg, dvs_next;
    logic [tasi_pkg::DUR_W:0]     shifted;
    logic [tasi_pkg::DUR_W+1:0]   diff;
    logic                         fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[tasi_pkg::QUO_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        fits      = ~diff[tasi_pkg::DUR_W+1];
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = tasi_pkg::CNT_W'(tasi_pkg::QUO_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_next = {quo_reg[tasi_pkg::QUO_W-2:0], fits};
            rem_next = fits ? diff[tasi_pkg::DUR_W-1:0] : shifted[tasi_pkg::DUR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `TASI_ASSERT_NOW(a_div_start_idle, start, !busy_reg, "divider restarted while busy")
    `TASI_ASSERT_NOW(a_div_nonzero, start, divisor != '0, "divider started with zero divisor")
    `TASI_ASSERT_NEXT(a_div_busy, start, busy_reg && !done_reg, "divider did not go busy")
    `TASI_ASSERT_NOW(a_div_done_free, done_reg, !busy_reg, "divider done while still busy")

endmodule

### hdl/two_axis_servo_interpolator.sv
`timescale 1ns / 1ps
// Channel   | Dir | Signals                         | Content
// s_axis    | in  | tvalid tready tdata[79:0] tuser | one tick request: times, positions, mode
// m_axis    | out | tvalid tready tdata[15:0] tuser | commanded positions and fault flag
//
// Flow: one request at a time. A jump, or an interpolation before any segment,
// passes from ST_CHECK through ST_DECIDE to ST_DONE when no segment latches.
// Longer requests use the shared bit-serial divider: one division by ten when a
// new segment latches, and one per axis when interpolating. The serial shift-add
// multiplier runs ahead of each division.
// Reset: rst_n clears the segment state and both handshakes; no clearing pass.
// Stalls: a finished result waits in the output register; the next request is taken
// meanwhile, and its own result waits in ST_DONE until the output register frees.
`include "two_axis_servo_interpolator_defines.svh"

module two_axis_servo_interpolator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // time_ms[31:0] from_angle[39:32] from_stroke[47:40] to_angle[55:48]
    // to_stroke[63:56] step_ms[79:64]
    input  logic [79:0] s_axis_tdata,
    // action[0]: 0 interpolate, 1 jump to end positions
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // angle_out[7:0] stroke_out[15:8]
    output logic [15:0] m_axis_tdata,
    // zero_duration_fault[0]
    output logic        m_axis_tuser
);

    tasi_pkg::state_t state_reg, state_next;

    // latched request
    logic                          jump_reg, jump_next;
    logic [tasi_pkg::TIME_W-1:0]   t_reg, t_next;
    logic [tasi_pkg::POS_W-1:0]    fa_reg, fa_next;
    logic [tasi_pkg::POS_W-1:0]    fs_reg, fs_next;
    logic [tasi_pkg::POS_W-1:0]    ta_reg, ta_next;
    logic [tasi_pkg::POS_W-1:0]    ts_reg, ts_next;
    logic [tasi_pkg::STEP_W-1:0]   sp_reg, sp_next;

    // segment state
    logic [tasi_pkg::TIME_W-1:0]   seg_end_reg, seg_end_next;
    logic [tasi_pkg::TIME_W-1:0]   seg_start_reg, seg_start_next;
    logic [tasi_pkg::POS_W-1:0]    a_span_reg, a_span_next;
    logic [tasi_pkg::POS_W-1:0]    s_span_reg, s_span_next;
    logic                          a_down_reg, a_down_next;
    logic                          s_down_reg, s_down_next;
    logic [tasi_pkg::DUR_W-1:0]    dur_reg, dur_next;

    // serial multiplier
    logic [tasi_pkg::TIME_W-1:0]   prod_reg, prod_next;
    logic [tasi_pkg::TIME_W-1:0]   mcand_reg, mcand_next;
    logic [tasi_pkg::POS_W-1:0]    mplier_reg, mplier_next;

    // per-request results and output register
    logic                          axis_reg, axis_next;
    logic [tasi_pkg::POS_W-1:0]    res_a_reg, res_a_next;
    logic [tasi_pkg::POS_W-1:0]    res_s_reg, res_s_next;
    logic                          res_f_reg, res_f_next;
    logic                          out_valid_reg, out_valid_next;
    logic [15:0]                   out_data_reg, out_data_next;
    logic                          out_fault_reg, out_fault_next;

    // divider hookup
    logic                          div_start;
    logic [tasi_pkg::QUO_W-1:0]    div_dividend;
    logic [tasi_pkg::DUR_W-1:0]    div_divisor;
    logic                          div_done;
    logic [tasi_pkg::QUO_W-1:0]    div_quo;
    logic [tasi_pkg::DUR_W-1:0]    div_rem;

    // helpers
    logic                          a_up, s_up;
    logic [tasi_pkg::POS_W-1:0]    a_span_new, s_span_new, longest;
    logic [tasi_pkg::TIME_W-1:0]   elapsed;
    logic [tasi_pkg::DUR_W-1:0]    dur_new;
    logic [tasi_pkg::POS_W-1:0]    pos_from, pos_new;
    logic                          pos_down;
    logic                          out_free;

    tasi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_axis_tready = (state_reg == tasi_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_fault_reg;

    always_comb
    begin
        a_up       = (fa_reg < ta_reg);
        s_up       = (fs_reg < ts_reg);
        a_span_new = a_up ? (ta_reg - fa_reg) : (fa_reg - ta_reg);
        s_span_new = s_up ? (ts_reg - fs_reg) : (fs_reg - ts_reg);
        longest    = (a_span_new > s_span_new) ? a_span_new : s_span_new;
        elapsed    = t_reg - seg_start_reg;
        // round down to a tick, then add one tick; product stays below 2^24
        dur_new    = prod_reg[tasi_pkg::DUR_W-1:0] - div_rem + tasi_pkg::TICK_MS;
        pos_from   = axis_reg ? fs_reg : fa_reg;
        pos_down   = axis_reg ? s_down_reg : a_down_reg;
        pos_new    = pos_down ? (pos_from - div_quo[tasi_pkg::POS_W-1:0])
                              : (pos_from + div_quo[tasi_pkg::POS_W-1:0]);
        out_free   = !out_valid_reg || m_axis_tready;
    end

    always_comb
    begin
        state_next     = state_reg;
        jump_next      = jump_reg;
        t_next         = t_reg;
        fa_next        = fa_reg;
        fs_next        = fs_reg;
        ta_next        = ta_reg;
        ts_next        = ts_reg;
        sp_next        = sp_reg;
        seg_end_next   = seg_end_reg;
        seg_start_next = seg_start_reg;
        a_span_next    = a_span_reg;
        s_span_next    = s_span_reg;
        a_down_next    = a_down_reg;
        s_down_next    = s_down_reg;
        dur_next       = dur_reg;
        prod_next      = prod_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        axis_next      = axis_reg;
        res_a_next     = res_a_reg;
        res_s_next     = res_s_reg;
        res_f_next     = res_f_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_fault_next = out_fault_reg;
        div_start      = 1'b0;
        div_dividend   = prod_reg;
        div_divisor    = dur_reg;

        // drop the result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tasi_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    jump_next  = s_axis_tuser;
                    t_next     = s_axis_tdata[31:0];
                    fa_next    = s_axis_tdata[39:32];
                    fs_next    = s_axis_tdata[47:40];
                    ta_next    = s_axis_tdata[55:48];
                    ts_next    = s_axis_tdata[63:56];
                    sp_next    = s_axis_tdata[79:64];
                    state_next = tasi_pkg::ST_CHECK;
                end
            end
            tasi_pkg::ST_CHECK:
            begin
                if (t_reg == seg_end_reg)
                begin
                    // latch a new segment, then size it: longest * step_ms
                    seg_start_next = t_reg;
                    a_span_next    = a_span_new;
                    s_span_next    = s_span_new;
                    a_down_next    = !a_up;
                    s_down_next    = !s_up;
                    prod_next      = '0;
                    mcand_next     = tasi_pkg::TIME_W'(sp_reg);
                    mplier_next    = longest;
                    state_next     = tasi_pkg::ST_SEG_MUL;
                end
                else
                begin
                    state_next = tasi_pkg::ST_DECIDE;
                end
            end
            tasi_pkg::ST_SEG_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    div_start   = 1'b1;
                    div_divisor = tasi_pkg::TICK_MS;
                    state_next  = tasi_pkg::ST_SEG_DIV;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[tasi_pkg::TIME_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[tasi_pkg::POS_W-1:1]};
                end
            end
            tasi_pkg::ST_SEG_DIV:
            begin
                if (div_done)
                begin
                    dur_next     = dur_new;
                    seg_end_next = t_reg + tasi_pkg::TIME_W'(dur_new)
                                 + tasi_pkg::TIME_W'(tasi_pkg::TICK_MS);
                    state_next   = tasi_pkg::ST_DECIDE;
                end
            end
            tasi_pkg::ST_DECIDE:
            begin
                if (jump_reg)
                begin
                    res_a_next = ta_reg;
                    res_s_next = ts_reg;
                    res_f_next = 1'b0;
                    state_next = tasi_pkg::ST_DONE;
                end
                else if (dur_reg == '0)
                begin
                    // no segment yet: hold the start positions and flag it
                    res_a_next = fa_reg;
                    res_s_next = fs_reg;
                    res_f_next = 1'b1;
                    state_next = tasi_pkg::ST_DONE;
                end
                else
                begin
                    res_f_next  = 1'b0;
                    axis_next   = 1'b0;
                    prod_next   = '0;
                    mcand_next  = elapsed;
                    mplier_next = a_span_reg;
                    state_next  = tasi_pkg::ST_AX_MUL;
                end
            end
            tasi_pkg::ST_AX_MUL:
            begin
                if (mplier_reg == '0)
                begin
                    div_start  = 1'b1;
                    state_next = tasi_pkg::ST_AX_DIV;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[tasi_pkg::TIME_W-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[tasi_pkg::POS_W-1:1]};
                end
            end
            tasi_pkg::ST_AX_DIV:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        // angle finished, advance to stroke
                        res_a_next  = pos_new;
                        axis_next   = 1'b1;
                        prod_next   = '0;
                        mcand_next  = elapsed;
                        mplier_next = s_span_reg;
                        state_next  = tasi_pkg::ST_AX_MUL;
                    end
                    else
                    begin
                        res_s_next = pos_new;
                        state_next = tasi_pkg::ST_DONE;
                    end
                end
            end
            tasi_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_s_reg, res_a_reg};
                    out_fault_next = res_f_reg;
                    state_next     = tasi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tasi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tasi_pkg::ST_IDLE;
            seg_end_reg   <= '0;
            seg_start_reg <= '0;
            a_span_reg    <= '0;
            s_span_reg    <= '0;
            a_down_reg    <= 1'b0;
            s_down_reg    <= 1'b0;
            dur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_end_reg   <= seg_end_next;
            seg_start_reg <= seg_start_next;
            a_span_reg    <= a_span_next;
            s_span_reg    <= s_span_next;
            a_down_reg    <= a_down_next;
            s_down_reg    <= s_down_next;
            dur_reg       <= dur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jump_reg      <= jump_next;
        t_reg         <= t_next;
        fa_reg        <= fa_next;
        fs_reg        <= fs_next;
        ta_reg        <= ta_next;
        ts_reg        <= ts_next;
        sp_reg        <= sp_next;
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        axis_reg      <= axis_next;
        res_a_reg     <= res_a_next;
        res_s_reg     <= res_s_next;
        res_f_reg     <= res_f_next;
        out_data_reg  <= out_data_next;
        out_fault_reg <= out_fault_next;
    end

    `TASI_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")
    `TASI_ASSERT_NOW(a_div_in_div_state, div_done, (state_reg == tasi_pkg::ST_SEG_DIV) || (state_reg == tasi_pkg::ST_AX_DIV), "divider finished outside a divide step")
    `TASI_ASSERT_NEXT(a_result_loaded, (state_reg == tasi_pkg::ST_DONE) && out_free, m_axis_tvalid, "result not presented")
    `TASI_ASSERT_NOW(a_seg_nonzero, state_reg == tasi_pkg::ST_AX_MUL, dur_reg != '0, "interpolating with zero duration")

endmodule
